// ----- design/rti_pkg.sv -----
// shared types, constants and arithmetic helpers for the ray/triangle intersection unit
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

   // field widths
   localparam int CW    = 16;             // coordinate lane, Q8.8
   localparam int NW    = 16;             // normal lane, Q1.14
   localparam int EW    = CW + 1;         // edge and offset vectors
   localparam int CRW   = 2 * EW + 1;     // cross product components
   localparam int PW    = EW + CRW;       // one dot product term
   localparam int DW    = PW + 2;         // determinant, signed
   localparam int MW    = DW - 1;         // determinant magnitude
   localparam int QW    = 31;             // quotient bits per divide
   localparam int DIV_STEPS = QW;
   localparam int FRAC  = 16;             // fraction bits of t and weights
   localparam int BW    = FRAC + 1;       // barycentric weight
   localparam int RW    = 48;             // packed vertex / normal register
   localparam int MDW   = 16;             // minimum distance register
   localparam int TDW   = 168;            // result tdata width

   localparam logic [QW-1:0]  DIST_MAX = {QW{1'b1}};
   localparam logic [BW:0]    WEIGHT_ONE = (BW + 1)'(1 << FRAC);

   // register map, index = paddr[5:3]
   localparam logic [2:0] REG_VERTEX_A = 3'd0;
   localparam logic [2:0] REG_VERTEX_B = 3'd1;
   localparam logic [2:0] REG_VERTEX_C = 3'd2;
   localparam logic [2:0] REG_NORMAL_A = 3'd3;
   localparam logic [2:0] REG_NORMAL_B = 3'd4;
   localparam logic [2:0] REG_NORMAL_C = 3'd5;
   localparam logic [2:0] REG_MIN_DIST = 3'd6;

   typedef enum logic [2:0] {
      CAUSE_HIT      = 3'd0,
      CAUSE_PARALLEL = 3'd1,
      CAUSE_BETA     = 3'd2,
      CAUSE_GAMMA    = 3'd3,
      CAUSE_CLOSE    = 3'd4
   } cause_type;

   typedef logic [2:0][CW-1:0]  cvec_type;
   typedef logic [2:0][EW-1:0]  evec_type;
   typedef logic [2:0][CRW-1:0] xvec_type;
   typedef logic [2:0][PW-1:0]  pvec_type;

   typedef struct packed {
      cvec_type org;
      cvec_type dir;
   } ray_type;

   typedef struct packed {
      logic [RW-1:0]  va;
      logic [RW-1:0]  vb;
      logic [RW-1:0]  vc;
      logic [RW-1:0]  na;
      logic [RW-1:0]  nb;
      logic [RW-1:0]  nc;
      logic [MDW-1:0] min_dist;
   } cfg_type;

   // one restoring divide lane: partial remainder and a shared
   // numerator-in / quotient-out shift register
   typedef struct packed {
      logic [MW-1:0] rem;
      logic [QW-1:0] nq;
   } lane_type;

   typedef struct packed {
      logic          valid;
      cause_type     cause;
      logic          sat;
      ray_type       ray;
      logic [MW-1:0] den;
      lane_type      t;
      lane_type      b;
      lane_type      g;
   } div_type;

   typedef struct packed {
      logic          hit;
      cause_type     cause;
      logic [QW-1:0] distance;
      cvec_type      point;
      cvec_type      shade;
      logic [BW-1:0] beta;
      logic [BW-1:0] gamma;
   } rsp_type;

   // sign extend one coordinate lane
   function automatic logic signed [EW-1:0] ext_coord(logic [CW-1:0] v);
      return {v[CW-1], v};
   endfunction

   // signed 17x17 product, widened to the cross product width
   function automatic logic signed [CRW-1:0] mul_e(logic signed [EW-1:0] a,
                                                   logic signed [EW-1:0] b);
      logic signed [2*EW-1:0] p;
      p = a * b;
      return {p[2*EW-1], p};
   endfunction

   // u x v
   function automatic xvec_type cross3(evec_type u, evec_type v);
      xvec_type c;
      c[0] = mul_e($signed(u[1]), $signed(v[2])) - mul_e($signed(u[2]), $signed(v[1]));
      c[1] = mul_e($signed(u[2]), $signed(v[0])) - mul_e($signed(u[0]), $signed(v[2]));
      c[2] = mul_e($signed(u[0]), $signed(v[1])) - mul_e($signed(u[1]), $signed(v[0]));
      return c;
   endfunction

   // componentwise products of a dot product
   function automatic pvec_type dot_terms(evec_type u, xvec_type c);
      pvec_type p;
      for (int k = 0; k < 3; k++) begin
         p[k] = $signed(u[k]) * $signed(c[k]);
      end
      return p;
   endfunction

   function automatic logic signed [DW-1:0] sum3(pvec_type p);
      logic signed [DW-1:0] s;
      s = DW'($signed(p[0])) + DW'($signed(p[1])) + DW'($signed(p[2]));
      return s;
   endfunction

   // one restoring divide step
   function automatic lane_type div_step(lane_type l, logic [MW-1:0] den);
      logic [MW:0] r2;
      logic [MW:0] diff;
      logic        ge;
      lane_type    o;
      r2   = {l.rem, l.nq[QW-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      o.rem = ge ? diff[MW-1:0] : r2[MW-1:0];
      o.nq  = {l.nq[QW-2:0], ge};
      return o;
   endfunction

   // saturate a signed value to one 16-bit lane
   function automatic logic [CW-1:0] sat16(logic signed [35:0] v);
      logic [CW-1:0] r;
      if (v > 36'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -36'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/rti_front.sv -----
// edge vectors, cross products, determinants and miss classification
`timescale 1ns / 1ps
`default_nettype none
module rti_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  rti_pkg::ray_type in_ray,
   input  rti_pkg::cfg_type cfg,
   output rti_pkg::div_type out_div
);

   // stage 1: edges and offset from vertex a
   rti_pkg::evec_type e1_in, e2_in, w_in, d_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = rti_pkg::ext_coord(cfg.va[16*k +: 16]) -
                    rti_pkg::ext_coord(cfg.vb[16*k +: 16]);
         e2_in[k] = rti_pkg::ext_coord(cfg.va[16*k +: 16]) -
                    rti_pkg::ext_coord(cfg.vc[16*k +: 16]);
         w_in[k]  = rti_pkg::ext_coord(cfg.va[16*k +: 16]) -
                    rti_pkg::ext_coord(in_ray.org[k]);
         d_in[k]  = rti_pkg::ext_coord(in_ray.dir[k]);
      end
   end

   logic              v1_ff;
   rti_pkg::ray_type  ray1_ff;
   rti_pkg::evec_type e1_1_ff, e2_1_ff, w1_ff, d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray1_ff <= in_ray;
         e1_1_ff <= e1_in;
         e2_1_ff <= e2_in;
         w1_ff   <= w_in;
         d1_ff   <= d_in;
      end
   end

   // stage 2: cross products e2 x d, d x e1, e1 x e2
   logic              v2_ff;
   rti_pkg::ray_type  ray2_ff;
   rti_pkg::evec_type e1_2_ff, w2_ff;
   rti_pkg::xvec_type c1_ff, c2_ff, c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray2_ff <= ray1_ff;
         e1_2_ff <= e1_1_ff;
         w2_ff   <= w1_ff;
         c1_ff   <= rti_pkg::cross3(e2_1_ff, d1_ff);
         c2_ff   <= rti_pkg::cross3(d1_ff, e1_1_ff);
         c3_ff   <= rti_pkg::cross3(e1_1_ff, e2_1_ff);
      end
   end

   // stage 3: dot product terms
   logic              v3_ff;
   rti_pkg::ray_type  ray3_ff;
   rti_pkg::pvec_type pden_ff, pnb_ff, png_ff, pnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray3_ff <= ray2_ff;
         pden_ff <= rti_pkg::dot_terms(e1_2_ff, c1_ff);
         pnb_ff  <= rti_pkg::dot_terms(w2_ff, c1_ff);
         png_ff  <= rti_pkg::dot_terms(w2_ff, c2_ff);
         pnt_ff  <= rti_pkg::dot_terms(w2_ff, c3_ff);
      end
   end

   // stage 4: determinant sums
   logic                          v4_ff;
   rti_pkg::ray_type              ray4_ff;
   logic signed [rti_pkg::DW-1:0] den4_ff, nb4_ff, ng4_ff, nt4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray4_ff <= ray3_ff;
         den4_ff <= rti_pkg::sum3(pden_ff);
         nb4_ff  <= rti_pkg::sum3(pnb_ff);
         ng4_ff  <= rti_pkg::sum3(png_ff);
         nt4_ff  <= rti_pkg::sum3(pnt_ff);
      end
   end

   // stage 5: sign fold, miss tests, divider seeds
   logic signed [rti_pkg::DW-1:0] den, nb, ng, nt;
   logic signed [rti_pkg::DW:0]   nbg;
   logic [rti_pkg::DW+15:0]       nt_wide, den_wide;
   rti_pkg::cause_type            cause;
   rti_pkg::div_type              div_in;

   always_comb begin
      den = den4_ff[rti_pkg::DW-1] ? -den4_ff : den4_ff;
      nb  = den4_ff[rti_pkg::DW-1] ? -nb4_ff  : nb4_ff;
      ng  = den4_ff[rti_pkg::DW-1] ? -ng4_ff  : ng4_ff;
      nt  = den4_ff[rti_pkg::DW-1] ? -nt4_ff  : nt4_ff;
      nbg = (rti_pkg::DW + 1)'(nb) + (rti_pkg::DW + 1)'(ng);

      priority if (den == '0) begin
         cause = rti_pkg::CAUSE_PARALLEL;
      end else if (nb < 0 || nb > den) begin
         cause = rti_pkg::CAUSE_BETA;
      end else if (ng < 0 || nbg > (rti_pkg::DW + 1)'(den)) begin
         cause = rti_pkg::CAUSE_GAMMA;
      end else if (nt <= 0) begin
         cause = rti_pkg::CAUSE_CLOSE;
      end else begin
         cause = rti_pkg::CAUSE_HIT;
      end

      // t saturates when nt * 2^16 / den reaches 2^31
      nt_wide  = {16'b0, nt};
      den_wide = {1'b0, den, 15'b0};

      div_in.valid = v4_ff;
      div_in.cause = cause;
      div_in.sat   = (nt_wide >= den_wide);
      div_in.ray   = ray4_ff;
      div_in.den   = den[rti_pkg::MW-1:0];
      div_in.t.rem = {15'b0, nt[rti_pkg::MW-1:15]};
      div_in.t.nq  = {nt[14:0], 16'b0};
      div_in.b.rem = {15'b0, nb[rti_pkg::MW-1:15]};
      div_in.b.nq  = {nb[14:0], 16'b0};
      div_in.g.rem = {15'b0, ng[rti_pkg::MW-1:15]};
      div_in.g.nq  = {ng[14:0], 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_div.valid <= 1'b0;
      end else if (en) begin
         out_div <= div_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rti_div.sv -----
// pipelined restoring divider, one quotient bit per stage for t, beta and gamma
`timescale 1ns / 1ps
`default_nettype none
module rti_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  rti_pkg::div_type in_div,
   output rti_pkg::div_type out_div
);

   rti_pkg::div_type st_ff [rti_pkg::DIV_STEPS];

   for (genvar i = 0; i < rti_pkg::DIV_STEPS; i++) begin : g_step
      rti_pkg::div_type prev;
      rti_pkg::div_type next;

      if (i == 0) begin : g_first
         assign prev = in_div;
      end else begin : g_rest
         assign prev = st_ff[i-1];
      end

      // all three lanes share the divisor
      always_comb begin
         next   = prev;
         next.t = rti_pkg::div_step(prev.t, prev.den);
         next.b = rti_pkg::div_step(prev.b, prev.den);
         next.g = rti_pkg::div_step(prev.g, prev.den);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i].valid <= 1'b0;
         end else if (en) begin
            st_ff[i] <= next;
         end
      end
   end

   assign out_div = st_ff[rti_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

// ----- design/rti_shade.sv -----
// distance test, hit point and interpolated normal
`timescale 1ns / 1ps
`default_nettype none
module rti_shade (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  rti_pkg::div_type in_div,
   input  rti_pkg::cfg_type cfg,
   output logic             out_valid,
   output rti_pkg::rsp_type out_rsp
);

   // stage 1: saturate t and compare with the minimum distance
   logic [rti_pkg::QW-1:0] t_clamp;
   logic [rti_pkg::QW-1:0] min_ext;
   logic                   exact;
   rti_pkg::cause_type     cause1;

   always_comb begin
      t_clamp = in_div.sat ? rti_pkg::DIST_MAX : in_div.t.nq;
      exact   = (in_div.t.rem == '0) && !in_div.sat;
      min_ext = {15'b0, cfg.min_dist};
      cause1  = in_div.cause;
      if (in_div.cause == rti_pkg::CAUSE_HIT &&
          (t_clamp < min_ext || (t_clamp == min_ext && exact))) begin
         cause1 = rti_pkg::CAUSE_CLOSE;
      end
   end

   logic                   v1_ff;
   rti_pkg::cause_type     cause1_ff;
   logic [rti_pkg::QW-1:0] dist1_ff;
   logic [rti_pkg::BW-1:0] bq1_ff, gq1_ff;
   rti_pkg::ray_type       ray1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_div.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cause1_ff <= cause1;
         dist1_ff  <= t_clamp;
         bq1_ff    <= in_div.b.nq[rti_pkg::BW-1:0];
         gq1_ff    <= in_div.g.nq[rti_pkg::BW-1:0];
         ray1_ff   <= in_div.ray;
      end
   end

   // stage 2: products for the point and the weighted normals
   logic signed [rti_pkg::BW:0] alpha, bq_s, gq_s;
   logic signed [rti_pkg::QW:0] dist_s;
   logic [2:0][47:0]            pp_in;
   logic [2:0][33:0]            sa_in, sb_in, sc_in;

   always_comb begin
      alpha  = $signed(rti_pkg::WEIGHT_ONE - {1'b0, bq1_ff} - {1'b0, gq1_ff});
      bq_s   = $signed({1'b0, bq1_ff});
      gq_s   = $signed({1'b0, gq1_ff});
      dist_s = $signed({1'b0, dist1_ff});
      for (int k = 0; k < 3; k++) begin
         pp_in[k] = dist_s * $signed(ray1_ff.dir[k]);
         sa_in[k] = alpha * $signed(cfg.na[16*k +: 16]);
         sb_in[k] = bq_s * $signed(cfg.nb[16*k +: 16]);
         sc_in[k] = gq_s * $signed(cfg.nc[16*k +: 16]);
      end
   end

   logic                   v2_ff;
   rti_pkg::cause_type     cause2_ff;
   logic [rti_pkg::QW-1:0] dist2_ff;
   logic [rti_pkg::BW-1:0] bq2_ff, gq2_ff;
   rti_pkg::cvec_type      org2_ff;
   logic [2:0][47:0]       pp_ff;
   logic [2:0][33:0]       sa_ff, sb_ff, sc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cause2_ff <= cause1_ff;
         dist2_ff  <= dist1_ff;
         bq2_ff    <= bq1_ff;
         gq2_ff    <= gq1_ff;
         org2_ff   <= ray1_ff.org;
         pp_ff     <= pp_in;
         sa_ff     <= sa_in;
         sb_ff     <= sb_in;
         sc_ff     <= sc_in;
      end
   end

   // stage 3: floor shift, add origin, saturate, zero on a miss
   logic signed [35:0] pt, sn;
   rti_pkg::rsp_type   rsp_in;

   always_comb begin
      rsp_in.hit      = (cause2_ff == rti_pkg::CAUSE_HIT);
      rsp_in.cause    = cause2_ff;
      rsp_in.distance = '0;
      rsp_in.point    = '0;
      rsp_in.shade    = '0;
      rsp_in.beta     = '0;
      rsp_in.gamma    = '0;
      pt = '0;
      sn = '0;
      for (int k = 0; k < 3; k++) begin
         pt = 36'($signed(org2_ff[k])) + 36'($signed(pp_ff[k][47:16]));
         sn = (36'($signed(sa_ff[k])) + 36'($signed(sb_ff[k])) +
               36'($signed(sc_ff[k]))) >>> 16;
         if (rsp_in.hit) begin
            rsp_in.point[k] = rti_pkg::sat16(pt);
            rsp_in.shade[k] = rti_pkg::sat16(sn);
         end
      end
      if (rsp_in.hit) begin
         rsp_in.distance = dist2_ff;
         rsp_in.beta     = bq2_ff;
         rsp_in.gamma    = gq2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_rsp <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/ray_triangle_intersect_unit.sv -----
// top level: register file, intersection pipeline and result skid buffer
//
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/tready      origin and direction of one ray
//  rsp_      out        rsp_tvalid/tready      hit flags, t, point, normal, weights
//  csr_      in         psel/penable/pready    triangle vertices, normals, min t
//
// one ray per cycle while req_tready is high; each result passes through the
// 31-stage restoring divider for t, beta and gamma plus eight arithmetic stages
// and the output register
// reset is synchronous and clears valid bits and the registers to their defaults
// a two-entry output buffer lets one more result arrive while the sink stalls;
// the whole pipeline holds only when both entries are full
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_intersect_unit (
   input  logic         clock,
   input  logic         reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (16 bits each)
   input  logic [95:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // distance(31), point_x/y/z(16), shade_nx/ny/nz(16), bary_beta(17),
   // bary_gamma(17), zero pad(7)
   output logic [167:0] rsp_tdata,
   // hit(1), miss_cause(3)
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   // configuration registers
   rti_pkg::cfg_type cfg_ff;
   logic [2:0]       csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.va       <= '0;
         cfg_ff.vb       <= '0;
         cfg_ff.vc       <= '0;
         cfg_ff.na       <= '0;
         cfg_ff.nb       <= '0;
         cfg_ff.nc       <= '0;
         cfg_ff.min_dist <= 16'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_index)
            rti_pkg::REG_VERTEX_A: cfg_ff.va <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_VERTEX_B: cfg_ff.vb <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_VERTEX_C: cfg_ff.vc <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_NORMAL_A: cfg_ff.na <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_NORMAL_B: cfg_ff.nb <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_NORMAL_C: cfg_ff.nc <= csr_pwdata[rti_pkg::RW-1:0];
            rti_pkg::REG_MIN_DIST: cfg_ff.min_dist <= csr_pwdata[rti_pkg::MDW-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         rti_pkg::REG_VERTEX_A: csr_prdata = {16'b0, cfg_ff.va};
         rti_pkg::REG_VERTEX_B: csr_prdata = {16'b0, cfg_ff.vb};
         rti_pkg::REG_VERTEX_C: csr_prdata = {16'b0, cfg_ff.vc};
         rti_pkg::REG_NORMAL_A: csr_prdata = {16'b0, cfg_ff.na};
         rti_pkg::REG_NORMAL_B: csr_prdata = {16'b0, cfg_ff.nb};
         rti_pkg::REG_NORMAL_C: csr_prdata = {16'b0, cfg_ff.nc};
         rti_pkg::REG_MIN_DIST: csr_prdata = {48'b0, cfg_ff.min_dist};
         default:               csr_prdata = '0;
      endcase
   end

   // pipeline advance: holds only while the skid entry is occupied
   logic             skid_valid_ff;
   logic             en;
   rti_pkg::ray_type in_ray;
   rti_pkg::div_type front_div, div_out;
   logic             pipe_valid;
   rti_pkg::rsp_type pipe_rsp;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign in_ray.org = req_tdata[47:0];
   assign in_ray.dir = req_tdata[95:48];

   rti_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_ray   (in_ray),
      .cfg      (cfg_ff),
      .out_div  (front_div)
   );

   rti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_div  (front_div),
      .out_div (div_out)
   );

   rti_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_div    (div_out),
      .cfg       (cfg_ff),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   // output register and skid entry
   logic             rsp_valid_ff;
   rti_pkg::rsp_type rsp_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!skid_valid_ff) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_ff <= pipe_valid;
         end else if (pipe_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_ff <= pipe_rsp;
         end else begin
            skid_ff <= pipe_rsp;
         end
      end else if (rsp_tready) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.cause, rsp_ff.hit};
   assign rsp_tdata  = {7'b0, rsp_ff.gamma, rsp_ff.beta, rsp_ff.shade, rsp_ff.point,
                        rsp_ff.distance};

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry occupied with empty output register");

   a_hit_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.hit == (rsp_ff.cause == rti_pkg::CAUSE_HIT)))
      else $error("hit flag disagrees with miss cause");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |->
      (rsp_ff.distance == '0 && rsp_ff.beta == '0 && rsp_ff.gamma == '0))
      else $error("miss result carries nonzero payload");

   a_weights_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |->
      (({1'b0, rsp_ff.beta} + {1'b0, rsp_ff.gamma}) <= rti_pkg::WEIGHT_ONE))
      else $error("barycentric weights sum above one");

endmodule
`default_nettype wire
